>>> hdl/gdfo_pkg.sv
// shared constants, types and helpers for the depth-first ordering block
package gdfo_pkg;

	localparam int NODE_SLOTS = 64;
	localparam int MAX_EDGES = 256;
	localparam int NODE_W    = 7;                       // node number 0..NODE_SLOTS
	localparam int NIDX_W    = $clog2(NODE_SLOTS);      // node index 0..NODE_SLOTS-1
	localparam int EPTR_W    = $clog2(MAX_EDGES) + 1;   // edge index + 1, zero is end of list
	localparam int EADDR_W   = $clog2(MAX_EDGES);
	localparam int DEPTH_W   = $clog2(NODE_SLOTS) + 1;
	localparam int EDGE_W    = EPTR_W + NODE_W;         // {next, target}
	localparam int STK_W     = EPTR_W + NODE_W;         // {cursor, node}
	localparam int S_DATA_W  = 16;
	localparam int M_DATA_W  = 8;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_RUN = 1'b1;

	typedef struct packed {
		logic              push;    // new node in preorder
		logic              fin;     // run over, release held node as last
		logic [NODE_W-1:0] node;
	} emit_req_t;

	typedef struct packed {
		logic can_go;               // a push or flush can be taken this cycle
		logic pend_vld;             // a node is held back
	} emit_sts_t;

	function automatic logic [NIDX_W-1:0] node_idx(input logic [NODE_W-1:0] n);
		logic [NODE_W-1:0] m;
		m = n - NODE_W'(1);
		return m[NIDX_W-1:0];
	endfunction

endpackage

>>> hdl/gdfo_emit.sv
// output stage: holds back the newest node so the final one can carry tlast
module gdfo_emit import gdfo_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  emit_req_t           req,
	output emit_sts_t           sts,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [M_DATA_W-1:0] m_axis_tdata,   // [6:0] visited_node, rest zero
	output logic                m_axis_tlast    // last
);

	logic              pend_vld_q;
	logic [NODE_W-1:0] pend_node_q;
	logic              out_vld_q;
	logic [NODE_W-1:0] out_node_q;
	logic              out_last_q;
	logic              out_free;
	logic              load;

	assign out_free     = !out_vld_q || m_axis_tready;
	assign sts.can_go   = !pend_vld_q || out_free;
	assign sts.pend_vld = pend_vld_q;
	assign load         = pend_vld_q && out_free && (req.push || req.fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (load)
				out_vld_q <= 1'b1;
			else if (m_axis_tready)
				out_vld_q <= 1'b0;
			if (req.push && sts.can_go)
				pend_vld_q <= 1'b1;
			else if (load)
				pend_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_node_q <= pend_node_q;
			out_last_q <= req.fin;
		end
		if (req.push && sts.can_go)
			pend_node_q <= req.node;
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(M_DATA_W - NODE_W){1'b0}}, out_node_q};
	assign m_axis_tlast  = out_last_q;

endmodule

>>> hdl/graph_depth_first_order_top.sv
// depth-first preorder over a directed graph kept in on-chip adjacency memories
// an add-edge word reads the list head, then writes the edge record and the new head
// a run word is accepted, sweeps the visited marks, then checks each root in turn,
// reads each edge tried, checks its target when in range, pops the stack, ends each tree, then ends
// the output word register may stall the walk when the downstream holds tready low
// reset clears control, node_count, edge count and list-head valid bits; no clearing pass
module graph_depth_first_order_top import gdfo_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wen,
	input  logic [NODE_W-1:0]   cfg_wdata,      // node_count
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [S_DATA_W-1:0] s_axis_tdata,   // [6:0] from_node, [13:7] to_node, rest zero
	input  logic [0:0]          s_axis_tuser,   // [0] operation
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [M_DATA_W-1:0] m_axis_tdata,   // [6:0] visited_node, rest zero
	output logic                m_axis_tlast    // last
);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_ADD      = 4'd1;
	localparam logic [3:0] ST_CLR      = 4'd2;
	localparam logic [3:0] ST_ROOT     = 4'd3;
	localparam logic [3:0] ST_ROOT_CHK = 4'd4;
	localparam logic [3:0] ST_EDGE     = 4'd5;
	localparam logic [3:0] ST_EDGE_CHK = 4'd6;
	localparam logic [3:0] ST_TGT_CHK  = 4'd7;
	localparam logic [3:0] ST_POP      = 4'd8;
	localparam logic [3:0] ST_FIN      = 4'd9;

	// memories
	logic [EPTR_W-1:0]    head_mem [NODE_SLOTS];
	logic [EDGE_W-1:0]    edge_mem [MAX_EDGES];
	logic                 vis_mem  [NODE_SLOTS];
	logic [STK_W-1:0]     stk_mem  [NODE_SLOTS];

	logic [NODE_SLOTS-1:0] head_vld_q;
	logic [EPTR_W-1:0]    head_rd_q;
	logic                 hvld_rd_q;
	logic                 vis_rd_q;
	logic [EDGE_W-1:0]    edge_rd_q;
	logic [STK_W-1:0]     stk_rd_q;

	logic [3:0]           st_q, st_d;
	logic [NODE_W-1:0]    node_count_q;
	logic [EPTR_W-1:0]    edges_used_q;
	logic [NODE_W-1:0]    add_src_q, add_dst_q;
	logic                 add_ok_q;
	logic [NODE_W-1:0]    root_q, root_d;
	logic [NODE_W-1:0]    top_node_q, top_node_d;
	logic [EPTR_W-1:0]    top_cur_q, top_cur_d;
	logic [DEPTH_W-1:0]   depth_q, depth_d;
	logic [NODE_W-1:0]    tgt_q, tgt_d;
	logic [NIDX_W-1:0]    clr_q;

	logic [NODE_W-1:0]    n_act;
	logic                 accept;
	logic [NODE_W-1:0]    in_src, in_dst;
	logic                 in_ok;
	logic [NODE_W-1:0]    e_tgt;
	logic [EPTR_W-1:0]    e_nxt;
	logic [EPTR_W-1:0]    hd;
	logic [DEPTH_W-1:0]   depth_m1, depth_m2;

	logic                 head_re, vis_re, vis_we, vis_wd, edge_re, stk_re, stk_we;
	logic [NIDX_W-1:0]    head_ra, vis_ra, vis_wa, stk_ra, stk_wa;
	logic [EADDR_W-1:0]   edge_ra;
	logic [EPTR_W-1:0]    cur_m1;

	emit_req_t            req;
	emit_sts_t            sts;

	assign n_act = (node_count_q > NODE_W'(NODE_SLOTS)) ? NODE_W'(NODE_SLOTS) : node_count_q;

	assign s_axis_tready = (st_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign in_src        = s_axis_tdata[NODE_W-1:0];
	assign in_dst        = s_axis_tdata[2*NODE_W-1:NODE_W];
	assign in_ok         = (in_src != '0) && (in_src <= n_act) && (in_dst != '0) &&
	                       (in_dst <= n_act) && (edges_used_q != EPTR_W'(MAX_EDGES));

	assign e_tgt    = edge_rd_q[NODE_W-1:0];
	assign e_nxt    = edge_rd_q[EDGE_W-1:NODE_W];
	assign hd       = hvld_rd_q ? head_rd_q : '0;
	assign depth_m1 = depth_q - DEPTH_W'(1);
	assign depth_m2 = depth_q - DEPTH_W'(2);
	assign cur_m1   = top_cur_q - EPTR_W'(1);

	always_comb begin
		st_d       = st_q;
		root_d     = root_q;
		top_node_d = top_node_q;
		top_cur_d  = top_cur_q;
		depth_d    = depth_q;
		tgt_d      = tgt_q;
		head_re    = 1'b0;
		head_ra    = '0;
		vis_re     = 1'b0;
		vis_ra     = '0;
		vis_we     = 1'b0;
		vis_wa     = '0;
		vis_wd     = 1'b0;
		edge_re    = 1'b0;
		edge_ra    = cur_m1[EADDR_W-1:0];
		stk_re     = 1'b0;
		stk_ra     = depth_m2[NIDX_W-1:0];
		stk_we     = 1'b0;
		stk_wa     = depth_m1[NIDX_W-1:0];
		req.push   = 1'b0;
		req.fin    = 1'b0;
		req.node   = '0;
		unique case (st_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_axis_tuser[0] == OP_ADD) begin
						head_re = 1'b1;
						head_ra = node_idx(in_src);
						st_d    = ST_ADD;
					end else begin
						root_d  = NODE_W'(1);
						depth_d = '0;
						st_d    = ST_CLR;
					end
				end
			end
			ST_ADD: begin
				st_d = ST_IDLE;
			end
			ST_CLR: begin
				vis_we = 1'b1;
				vis_wa = clr_q;
				if (clr_q == NIDX_W'(NODE_SLOTS - 1))
					st_d = ST_ROOT;
			end
			ST_ROOT: begin
				if (root_q > n_act) begin
					st_d = ST_FIN;
				end else begin
					vis_re  = 1'b1;
					vis_ra  = node_idx(root_q);
					head_re = 1'b1;
					head_ra = node_idx(root_q);
					st_d    = ST_ROOT_CHK;
				end
			end
			ST_ROOT_CHK: begin
				if (vis_rd_q) begin
					root_d = root_q + NODE_W'(1);
					st_d   = ST_ROOT;
				end else if (sts.can_go) begin
					vis_we     = 1'b1;
					vis_wa     = node_idx(root_q);
					vis_wd     = 1'b1;
					top_node_d = root_q;
					top_cur_d  = hd;
					depth_d    = DEPTH_W'(1);
					req.push   = 1'b1;
					req.node   = root_q;
					st_d       = ST_EDGE;
				end
			end
			ST_EDGE: begin
				if (top_cur_q != '0) begin
					edge_re = 1'b1;
					st_d    = ST_EDGE_CHK;
				end else if (depth_q == DEPTH_W'(1)) begin
					// tree finished, resume the root scan
					depth_d = '0;
					root_d  = root_q + NODE_W'(1);
					st_d    = ST_ROOT;
				end else begin
					stk_re  = 1'b1;
					depth_d = depth_m1;
					st_d    = ST_POP;
				end
			end
			ST_EDGE_CHK: begin
				top_cur_d = e_nxt;
				if (e_tgt != '0 && e_tgt <= n_act) begin
					vis_re  = 1'b1;
					vis_ra  = node_idx(e_tgt);
					head_re = 1'b1;
					head_ra = node_idx(e_tgt);
					tgt_d   = e_tgt;
					st_d    = ST_TGT_CHK;
				end else begin
					st_d = ST_EDGE;
				end
			end
			ST_TGT_CHK: begin
				if (vis_rd_q) begin
					st_d = ST_EDGE;
				end else if (sts.can_go) begin
					stk_we     = 1'b1;
					vis_we     = 1'b1;
					vis_wa     = node_idx(tgt_q);
					vis_wd     = 1'b1;
					top_node_d = tgt_q;
					top_cur_d  = hd;
					depth_d    = depth_q + DEPTH_W'(1);
					req.push   = 1'b1;
					req.node   = tgt_q;
					st_d       = ST_EDGE;
				end
			end
			ST_POP: begin
				top_node_d = stk_rd_q[NODE_W-1:0];
				top_cur_d  = stk_rd_q[STK_W-1:NODE_W];
				st_d       = ST_EDGE;
			end
			ST_FIN: begin
				if (!sts.pend_vld) begin
					st_d = ST_IDLE;
				end else if (sts.can_go) begin
					req.fin = 1'b1;
					st_d    = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			node_count_q <= '0;
			edges_used_q <= '0;
			head_vld_q   <= '0;
			clr_q        <= '0;
			root_q       <= '0;
			depth_q      <= '0;
		end else begin
			st_q    <= st_d;
			root_q  <= root_d;
			depth_q <= depth_d;
			if (cfg_wen)
				node_count_q <= cfg_wdata;
			if (st_q == ST_CLR)
				clr_q <= clr_q + NIDX_W'(1);
			else
				clr_q <= '0;
			if (st_q == ST_ADD && add_ok_q) begin
				edges_used_q                   <= edges_used_q + EPTR_W'(1);
				head_vld_q[node_idx(add_src_q)] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_node_q <= top_node_d;
		top_cur_q  <= top_cur_d;
		tgt_q      <= tgt_d;
		if (accept) begin
			add_src_q <= in_src;
			add_dst_q <= in_dst;
			add_ok_q  <= in_ok;
		end
	end

	// list heads
	always_ff @(posedge clk) begin
		if (head_re) begin
			head_rd_q <= head_mem[head_ra];
			hvld_rd_q <= head_vld_q[head_ra];
		end
		if (st_q == ST_ADD && add_ok_q)
			head_mem[node_idx(add_src_q)] <= edges_used_q + EPTR_W'(1);
	end

	// edge records, new edge links to the old head
	always_ff @(posedge clk) begin
		if (edge_re)
			edge_rd_q <= edge_mem[edge_ra];
		if (st_q == ST_ADD && add_ok_q)
			edge_mem[edges_used_q[EADDR_W-1:0]] <= {hd, add_dst_q};
	end

	// visited marks
	always_ff @(posedge clk) begin
		if (vis_re)
			vis_rd_q <= vis_mem[vis_ra];
		if (vis_we)
			vis_mem[vis_wa] <= vis_wd;
	end

	// walk stack below the cached top entry
	always_ff @(posedge clk) begin
		if (stk_re)
			stk_rd_q <= stk_mem[stk_ra];
		if (stk_we)
			stk_mem[stk_wa] <= {top_cur_q, top_node_q};
	end

	gdfo_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.sts           (sts),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

>>> sim/graph_depth_first_order_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the depth-first ordering block with random graphs and stalls
module graph_depth_first_order_top_tb;
	import gdfo_pkg::*;

	localparam int CYCLE_LIMIT   = 2000000;
	localparam int SETTLE_CYCLES = 200;
	localparam int LONG_HOLD     = 300;
	localparam int FIELD_MAX     = (1 << NODE_W) - 1;

	typedef struct {
		logic [NODE_W-1:0] node;
		logic              last;
	} visit_t;

	class preorder_scoreboard;
		logic [NODE_W-1:0] node_count;
		logic [EPTR_W-1:0] list_head [NODE_SLOTS];
		logic [NODE_W-1:0] edge_target [MAX_EDGES];
		logic [EPTR_W-1:0] edge_next [MAX_EDGES];
		int unsigned       edges_used;
		visit_t            pending_visits [$];
		int                mismatches;

		function new();
			node_count = '0;
			edges_used = 0;
			mismatches = 0;
			foreach (list_head[i]) list_head[i] = '0;
		endfunction

		function int unsigned active_nodes();
			return (node_count > NODE_SLOTS) ? NODE_SLOTS : node_count;
		endfunction

		function void set_node_count(logic [NODE_W-1:0] value);
			node_count = value;
		endfunction

		function void add_edge(logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst);
			int unsigned n;
			n = active_nodes();
			if (src < 1 || src > n || dst < 1 || dst > n) return;
			if (edges_used >= MAX_EDGES) return;
			edge_target[edges_used] = dst;
			edge_next[edges_used]   = list_head[src - 1];
			list_head[src - 1]      = EPTR_W'(edges_used + 1);
			edges_used++;
		endfunction

		function void predict_preorder();
			logic [EPTR_W-1:0] cursor [NODE_SLOTS];
			bit                seen [NODE_SLOTS];
			logic [NODE_W-1:0] order [$];
			logic [EPTR_W-1:0] cur;
			logic [NODE_W-1:0] found;
			logic [NODE_W-1:0] tgt;
			int unsigned       n;
			int unsigned       sp;
			visit_t            v;
			n = active_nodes();
			foreach (seen[i]) seen[i] = 1'b0;
			for (int unsigned root = 1; root <= n; root++) begin
				if (seen[root - 1]) continue;
				seen[root - 1] = 1'b1;
				order.push_back(NODE_W'(root));
				cursor[0] = list_head[root - 1];
				sp = 1;
				while (sp > 0) begin
					cur = cursor[sp - 1];
					found = '0;
					// newest edge first; targets above the live node count are skipped
					while (cur != 0 && found == 0) begin
						tgt = edge_target[cur - 1];
						cur = edge_next[cur - 1];
						if (tgt >= 1 && tgt <= n && !seen[tgt - 1]) found = tgt;
					end
					cursor[sp - 1] = cur;
					if (found != 0) begin
						seen[found - 1] = 1'b1;
						order.push_back(found);
						if (sp < NODE_SLOTS) begin
							cursor[sp] = list_head[found - 1];
							sp++;
						end
					end else begin
						sp--;
					end
				end
			end
			foreach (order[i]) begin
				v.node = order[i];
				v.last = (i == order.size() - 1);
				pending_visits.push_back(v);
			end
		endfunction

		function void note_word(logic op, logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst);
			if (op == OP_ADD) add_edge(src, dst);
			else predict_preorder();
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			mismatches++;
		endtask

		task check_word(logic [NODE_W-1:0] node, logic last);
			visit_t want;
			if (pending_visits.size() == 0) begin
				report($sformatf("unexpected word, node %0d last %0b", node, last));
				return;
			end
			want = pending_visits.pop_front();
			if (node !== want.node)
				report($sformatf("visited_node %0d, wanted %0d", node, want.node));
			if (last !== want.last)
				report($sformatf("last %0b on node %0d, wanted %0b", last, node, want.last));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_wen;
	logic [NODE_W-1:0]   cfg_wdata;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata;   // [6:0] from_node, [13:7] to_node, rest zero
	logic [0:0]          s_axis_tuser;   // [0] operation
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [M_DATA_W-1:0] m_axis_tdata;   // [6:0] visited_node, rest zero
	logic                m_axis_tlast;

	preorder_scoreboard sb = new();
	int                 send_idle_pct;
	int                 recv_idle_pct;
	bit                 long_hold_req;
	int                 cycle_count;

	graph_depth_first_order_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_word(m_axis_tdata[NODE_W-1:0], m_axis_tlast);
	end

	// receiver: random backpressure, or one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				m_axis_tready <= 1'b0;
				for (int hold = 0; hold < LONG_HOLD; hold++) @(negedge clk);
				long_hold_req = 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// called right after an accepted word or while tvalid is low
	task send_word(logic op, logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, dst, src};
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_word(op, src, dst);
	endtask

	task stop_sending();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task wait_drained();
		while (sb.pending_visits.size() != 0) @(posedge clk);
	endtask

	// an add or an empty run leaves no word behind, so give the block time to go idle
	task settle();
		stop_sending();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task write_node_count(logic [NODE_W-1:0] value);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wen   <= 1'b0;
		sb.set_node_count(value);
	endtask

	task random_edges_and_runs(int count, int pause_at);
		int unsigned n;
		int unsigned roll;
		for (int i = 0; i < count; i++) begin
			n = sb.active_nodes();
			roll = $urandom_range(99);
			if (roll < 10)
				send_word(OP_RUN, NODE_W'($urandom_range(FIELD_MAX)),
					NODE_W'($urandom_range(FIELD_MAX)));
			else if (roll < 85 && n > 0)
				send_word(OP_ADD, NODE_W'($urandom_range(n, 1)), NODE_W'($urandom_range(n, 1)));
			else
				send_word(OP_ADD, NODE_W'($urandom_range(FIELD_MAX)),
					NODE_W'($urandom_range(FIELD_MAX)));
			if (i == pause_at) begin
				stop_sending();
				wait_drained();
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_wen       = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_ADD;
		long_hold_req = 1'b0;
		send_idle_pct = 28;
		recv_idle_pct = 53;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// no nodes yet: empty run, edge dropped
		send_word(OP_RUN, 7'd5, 7'd9);
		send_word(OP_ADD, 7'd1, 7'd2);
		settle();

		write_node_count(7'd6);
		send_word(OP_ADD, 7'd1, 7'd2);
		send_word(OP_ADD, 7'd1, 7'd3);
		send_word(OP_ADD, 7'd2, 7'd4);
		send_word(OP_ADD, 7'd4, 7'd1);
		send_word(OP_ADD, 7'd3, 7'd4);
		send_word(OP_ADD, 7'd5, 7'd5);
		send_word(OP_ADD, 7'd2, 7'd6);
		send_word(OP_ADD, 7'd0, 7'd1);
		send_word(OP_ADD, 7'd1, 7'd0);
		send_word(OP_ADD, 7'd7, 7'd1);
		send_word(OP_ADD, 7'd1, 7'd7);
		send_word(OP_ADD, 7'd127, 7'd127);
		send_word(OP_RUN, 7'd127, 7'd127);
		settle();

		// shrunken count: edges into nodes above three are skipped
		write_node_count(7'd3);
		send_word(OP_RUN, 7'd0, 7'd0);
		settle();

		// oversized count behaves as the full node range
		write_node_count(7'd127);
		send_word(OP_ADD, 7'd64, 7'd1);
		send_word(OP_ADD, 7'd1, 7'd64);
		send_word(OP_ADD, 7'd65, 7'd1);
		send_word(OP_RUN, 7'd42, 7'd85);
		settle();

		write_node_count(7'd1);
		send_word(OP_RUN, 7'd0, 7'd0);
		settle();

		// the first run meets a long receiver hold-off and backs up the input
		write_node_count(7'd64);
		long_hold_req = 1'b1;
		send_word(OP_RUN, 7'd0, 7'd0);
		random_edges_and_runs(45, -1);
		settle();

		send_idle_pct = 53;
		recv_idle_pct = 28;
		write_node_count(NODE_W'($urandom_range(20, 2)));
		random_edges_and_runs(45, 22);
		settle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_node_count(NODE_W'($urandom_range(63, 20)));
		random_edges_and_runs(45, -1);
		settle();

		// whole graph, then a smaller view of it, then no nodes at all
		write_node_count(7'd64);
		send_word(OP_RUN, 7'd0, 7'd0);
		settle();
		write_node_count(NODE_W'($urandom_range(40, 10)));
		send_word(OP_RUN, 7'd0, 7'd0);
		settle();
		write_node_count(7'd0);
		send_word(OP_RUN, 7'd0, 7'd0);

		stop_sending();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending_visits.size() != 0)
			sb.report($sformatf("%0d nodes never arrived", sb.pending_visits.size()));
		if (sb.mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

>>> sim.f
hdl/gdfo_pkg.sv
hdl/gdfo_emit.sv
hdl/graph_depth_first_order_top.sv
sim/graph_depth_first_order_top_tb.sv
